>>> rtl/adpr_pkg.sv
`timescale 1ns / 1ps

package adpr_pkg;

    localparam int BLOCK_LEN_DEF = 8;
    localparam int QUEUE_DEPTH   = 2;

    localparam int SAMPLE_W = 12;
    localparam int CODE_W   = 12;
    localparam int DUTY_W   = 16;
    localparam int STEP_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Largest scaled code: 4095 * 4 / 5 + 28.
    localparam int CODE_MAX    = 3304;
    localparam logic [CODE_W-1:0] CODE_OFFSET = 12'd28;
    // floor(y / 5) == (y * 52429) >> 18 for every 14-bit y.
    localparam logic [15:0] DIV5_RECIP = 16'd52429;
    localparam int DIV5_SHIFT = 18;

    localparam logic [STEP_W-1:0] STEP_RST = 16'd1;

    localparam logic [CFG_IDX_W-1:0] REG_SET_POINT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_ABOVE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_BELOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OK_ABOVE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OK_BELOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_STEP = 3'd5;

    typedef struct packed {
        logic [CODE_W-1:0] set_point;
        logic [CODE_W-1:0] band_above;
        logic [CODE_W-1:0] band_below;
        logic [CODE_W-1:0] ok_above;
        logic [CODE_W-1:0] ok_below;
    } t_cfg;

    typedef struct packed {
        logic              load;
        logic [STEP_W-1:0] value;
    } t_step_load;

endpackage

>>> rtl/adpr_front.sv
`timescale 1ns / 1ps

module adpr_front
    import adpr_pkg::*;
#(
    parameter int BLOCK_LEN = BLOCK_LEN_DEF,
    parameter int SUM_W     = 15
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_push,
    input  logic                i_full,
    output logic [SUM_W-1:0]    o_sum
);

    localparam int CNT_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_LEN - 1);

    logic              r_code_vld;
    logic [CODE_W-1:0] r_code;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;

    logic [13:0]       w_scaled;
    logic [29:0]       w_prod;
    logic [CODE_W-1:0] w_code;
    logic              w_last;
    logic              w_go;
    logic [SUM_W-1:0]  w_sum_next;

    assign w_scaled = {i_sample, 2'b00};
    assign w_prod   = 30'(w_scaled) * 30'(DIV5_RECIP);
    assign w_code   = w_prod[DIV5_SHIFT +: CODE_W] + CODE_OFFSET;

    assign w_last     = (r_cnt == CNT_LAST);
    // A block-closing code waits until the queue has room.
    assign w_go       = r_code_vld && !(w_last && i_full);
    assign w_sum_next = r_sum + SUM_W'(r_code);

    assign o_ready = !r_code_vld || w_go;
    assign o_push  = w_go && w_last;
    assign o_sum   = w_sum_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_vld <= 1'b0;
            r_sum      <= '0;
            r_cnt      <= '0;
        end else begin
            if (o_ready) begin
                r_code_vld <= i_valid;
            end
            if (w_go) begin
                if (w_last) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sum <= w_sum_next;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_code <= w_code;
        end
    end

endmodule

>>> rtl/adpr_queue.sv
`timescale 1ns / 1ps

module adpr_queue #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic w_do_push;
    logic w_do_pop;

    assign o_full    = (r_count == CNT_FULL);
    assign o_valid   = (r_count != '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/adpr_back.sv
`timescale 1ns / 1ps

module adpr_back
    import adpr_pkg::*;
#(
    parameter int BLOCK_LEN = BLOCK_LEN_DEF,
    parameter int SUM_W     = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_step_load        i_step_load,
    input  logic              i_valid,
    output logic              o_pop,
    input  logic [SUM_W-1:0]  i_sum,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CODE_W-1:0] o_average,
    output logic [DUTY_W-1:0] o_duty,
    output logic              o_in_band
);

    // Exact division by BLOCK_LEN through a reciprocal over the whole sum range.
    localparam int LOG_D   = $clog2(BLOCK_LEN);
    localparam int SH      = SUM_W + LOG_D;
    localparam int RECIP_W = SH + 1;
    localparam longint RECIP_VAL = ((64'd1 << SH) + BLOCK_LEN - 1) / BLOCK_LEN;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam int PROD_W  = SUM_W + RECIP_W;

    logic              r_avg_vld;
    logic [CODE_W-1:0] r_avg;
    logic              r_out_vld;
    logic [CODE_W-1:0] r_out_avg;
    logic [DUTY_W-1:0] r_duty;
    logic              r_in_band;
    logic [STEP_W-1:0] r_step;

    logic [PROD_W-1:0] w_prod;
    logic              w_out_go;
    logic [CODE_W:0]   w_avg_x;
    logic              w_in_dead;
    logic              w_in_ok;
    logic [DUTY_W-1:0] n_duty;
    logic [STEP_W-1:0] n_step;

    assign w_prod = PROD_W'(i_sum) * PROD_W'(RECIP);

    assign w_out_go = r_avg_vld && (!r_out_vld || i_ready);
    assign o_pop    = !r_avg_vld || w_out_go;

    // Bands compared one bit wider so neither edge can wrap.
    assign w_avg_x   = {1'b0, r_avg};
    assign w_in_dead = (w_avg_x <= {1'b0, i_cfg.set_point} + {1'b0, i_cfg.band_above})
                    && (w_avg_x + {1'b0, i_cfg.band_below} >= {1'b0, i_cfg.set_point});
    assign w_in_ok   = (w_avg_x <= {1'b0, i_cfg.set_point} + {1'b0, i_cfg.ok_above})
                    && (w_avg_x + {1'b0, i_cfg.ok_below} >= {1'b0, i_cfg.set_point});

    always_comb begin
        n_duty = r_duty;
        if (!w_in_dead) begin
            if (r_avg > i_cfg.set_point) begin
                n_duty = r_duty - r_step;
            end else begin
                n_duty = r_duty + r_step;
            end
        end
        n_step = (r_step > STEP_RST) ? (r_step >> 1) : r_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_duty    <= '0;
            r_step    <= STEP_RST;
        end else begin
            if (o_pop) begin
                r_avg_vld <= i_valid;
            end
            if (w_out_go) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_out_go) begin
                r_duty <= n_duty;
            end
            if (i_step_load.load) begin
                r_step <= i_step_load.value;
            end else if (w_out_go) begin
                r_step <= n_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_avg <= w_prod[SH +: CODE_W];
        end
        if (w_out_go) begin
            r_out_avg <= r_avg;
            r_in_band <= w_in_ok;
        end
    end

    assign o_valid   = r_out_vld;
    assign o_average = r_out_avg;
    assign o_duty    = r_duty;
    assign o_in_band = r_in_band;

endmodule

>>> rtl/averaged_deadband_pwm_regulator.sv
`timescale 1ns / 1ps

// Averaged deadband PWM regulator.
// Slave stream s_*: one raw 12-bit converter sample per transfer.
// Master stream m_*: one result per block of BLOCK_LEN samples, carrying the
// block average of the scaled codes, the duty after the regulation step and
// the in-band status bit.
// Configuration: write i_cfg_data to register i_cfg_index whenever
// i_cfg_wr_en is high; index 0 set point, 1 and 2 deadband above and below,
// 3 and 4 status band above and below, 5 initial step (also loads the step).
// Write configuration only while no block is in flight.
// Throughput: one sample per cycle while s_tready is high. The front scales and
// accumulates, a two-entry queue of block sums decouples it from the back, which
// divides by BLOCK_LEN through a reciprocal multiply and then runs the step.
// A block's last code is registered in the front, its sum then enters the
// queue, and the back registers the average and then the output result.
// Reset clears the sum, count, duty and configuration and sets the step to 1.
// When the receiver stalls, the output register holds, the back then the
// queue fill, and s_tready falls only when a block-closing sample finds the
// queue full.

module averaged_deadband_pwm_regulator
    import adpr_pkg::*;
#(
    parameter int BLOCK_LEN = BLOCK_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,    // [11:0] adc_sample, [15:12] zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,    // [11:0] average_code, [27:12] duty,
                                             // [28] in_band, [31:29] zero
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int SUM_W = $clog2(CODE_MAX * BLOCK_LEN + 1);

    t_cfg       r_cfg;
    t_step_load w_step_load;

    logic             w_push;
    logic             w_full;
    logic [SUM_W-1:0] w_push_sum;
    logic             w_q_valid;
    logic             w_pop;
    logic [SUM_W-1:0] w_q_sum;

    logic [CODE_W-1:0] w_avg;
    logic [DUTY_W-1:0] w_duty;
    logic              w_in_band;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_SET_POINT:  r_cfg.set_point  <= i_cfg_data[CODE_W-1:0];
                REG_BAND_ABOVE: r_cfg.band_above <= i_cfg_data[CODE_W-1:0];
                REG_BAND_BELOW: r_cfg.band_below <= i_cfg_data[CODE_W-1:0];
                REG_OK_ABOVE:   r_cfg.ok_above   <= i_cfg_data[CODE_W-1:0];
                REG_OK_BELOW:   r_cfg.ok_below   <= i_cfg_data[CODE_W-1:0];
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    assign w_step_load.load  = i_cfg_wr_en && (i_cfg_index == REG_INITIAL_STEP);
    assign w_step_load.value = i_cfg_data[STEP_W-1:0];

    adpr_front #(
        .BLOCK_LEN (BLOCK_LEN),
        .SUM_W     (SUM_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .o_ready  (s_tready),
        .i_sample (s_tdata[SAMPLE_W-1:0]),
        .o_push   (w_push),
        .i_full   (w_full),
        .o_sum    (w_push_sum)
    );

    adpr_queue #(
        .WIDTH (SUM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_sum),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_sum)
    );

    adpr_back #(
        .BLOCK_LEN (BLOCK_LEN),
        .SUM_W     (SUM_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_step_load (w_step_load),
        .i_valid     (w_q_valid),
        .o_pop       (w_pop),
        .i_sum       (w_q_sum),
        .o_valid     (m_tvalid),
        .i_ready     (m_tready),
        .o_average   (w_avg),
        .o_duty      (w_duty),
        .o_in_band   (w_in_band)
    );

    assign m_tdata = {3'b000, w_in_band, w_duty, w_avg};

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import adpr_pkg::*;

    localparam int BLK           = BLOCK_LEN_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 8;

    // Indexes that decode to no register.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [CODE_W-1:0] average_code;
        logic [DUTY_W-1:0] duty;
        logic              in_band;
    } t_block_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;    // [11:0] adc_sample, [15:12] zero
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;    // [11:0] average_code, [27:12] duty,
                                      // [28] in_band, [31:29] zero
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    // Shadow copy of the regulator state.
    t_cfg              cfg_shadow;
    logic [STEP_W-1:0] step_shadow;
    logic [DUTY_W-1:0] duty_shadow;
    int                sample_tally;
    int                code_total;

    t_block_result expected_blocks[$];
    int            mismatch_count;
    bit            stall_en;
    int            quiet_cycles;

    averaged_deadband_pwm_regulator #(
        .BLOCK_LEN(BLK)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // The band limits are compared as plain integers so that they never wrap.
    function automatic bit in_window(input int avg, input logic [CODE_W-1:0] above,
                                     input logic [CODE_W-1:0] below);
        int sp;
        sp = int'(cfg_shadow.set_point);
        return (avg <= sp + int'(above)) && (avg >= sp - int'(below));
    endfunction

    function automatic void accumulate_and_regulate(input logic [SAMPLE_W-1:0] smp);
        int            avg;
        t_block_result res;
        code_total += int'(smp) * 4 / 5 + 28;
        sample_tally++;
        if (sample_tally == BLK) begin
            avg          = code_total / BLK;
            code_total   = 0;
            sample_tally = 0;
            if (!in_window(avg, cfg_shadow.band_above, cfg_shadow.band_below)) begin
                if (avg > int'(cfg_shadow.set_point)) begin
                    duty_shadow = duty_shadow - step_shadow;
                end else begin
                    duty_shadow = duty_shadow + step_shadow;
                end
            end
            if (step_shadow > 1) begin
                step_shadow = step_shadow >> 1;
            end
            res.average_code = avg[CODE_W-1:0];
            res.duty         = duty_shadow;
            res.in_band      = in_window(avg, cfg_shadow.ok_above, cfg_shadow.ok_below);
            expected_blocks.push_back(res);
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        case (idx)
            REG_SET_POINT:    cfg_shadow.set_point  = val[CODE_W-1:0];
            REG_BAND_ABOVE:   cfg_shadow.band_above = val[CODE_W-1:0];
            REG_BAND_BELOW:   cfg_shadow.band_below = val[CODE_W-1:0];
            REG_OK_ABOVE:     cfg_shadow.ok_above   = val[CODE_W-1:0];
            REG_OK_BELOW:     cfg_shadow.ok_below   = val[CODE_W-1:0];
            REG_INITIAL_STEP: step_shadow           = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        if (stall_en && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(16 - SAMPLE_W){1'b0}}, smp};
        do @(posedge i_clk); while (!s_tready);
        accumulate_and_regulate(smp);
        @(negedge i_clk);
    endtask

    // The sender holds off until every block result has been taken, then lets
    // the pipeline settle so that configuration can be written safely.
    task automatic wait_for_results();
        s_tvalid = 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Reset values: zero set point and bands, unit step. Any average lies above
    // the set point, so the duty drops from zero and wraps.
    task automatic test_reset_defaults();
        logic [SAMPLE_W-1:0] pattern [BLK] = '{12'h000, 12'hFFF, 12'hAAA, 12'h555,
                                               12'h001, 12'h800, 12'hFFE, 12'h7FF};
        foreach (pattern[i]) send_sample(pattern[i]);
    endtask

    // Set point at the top of the 12-bit range with wide bands: the upper limits
    // go past 4095 and must not wrap. A full-scale step makes the duty wrap
    // upwards. The spare indexes are written with junk that must be ignored.
    task automatic test_band_wrap_and_step_load();
        wait_for_results();
        write_reg(REG_SET_POINT, 16'hFFFF);
        write_reg(REG_BAND_ABOVE, 16'h0FFF);
        write_reg(REG_BAND_BELOW, 16'hF064);
        write_reg(REG_OK_ABOVE, 16'h0FFF);
        write_reg(REG_OK_BELOW, 16'hFFFF);
        write_reg(REG_INITIAL_STEP, 16'hFFFF);
        write_reg(REG_SPARE_6, 16'h0000);
        write_reg(REG_SPARE_7, 16'hFFFF);
        repeat (BLK) send_sample(12'hFFF);
    endtask

    // Status band reaching below zero, and a zero step that leaves the duty put.
    task automatic test_zero_step_signed_window();
        wait_for_results();
        write_reg(REG_SET_POINT, 16'h000A);
        write_reg(REG_BAND_ABOVE, 16'h0000);
        write_reg(REG_BAND_BELOW, 16'h0FFF);
        write_reg(REG_OK_ABOVE, 16'h0FFF);
        write_reg(REG_OK_BELOW, 16'h0FFF);
        write_reg(REG_INITIAL_STEP, 16'h0000);
        repeat (BLK) send_sample(12'h000);
    endtask

    function automatic logic [CFG_W-1:0] pick_band();
        logic [3:0]        junk;
        logic [CODE_W-1:0] width;
        junk = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 5))
            0:       width = '0;
            1:       width = 12'hFFF;
            2:       width = 12'(CODE_MAX);
            default: width = 12'($urandom_range(0, 300));
        endcase
        return {junk, width};
    endfunction

    // Each phase centres the samples on a random level and mostly puts the set
    // point near its code, so the duty moves both ways and the bands matter.
    task automatic test_random_phases();
        int center;
        int spread;
        int blocks;
        int smp;
        int sp;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_for_results();
            stall_en = (ph < RANDOM_PHASES - 2) && ($urandom_range(0, 4) != 0);
            center   = $urandom_range(0, 4095);
            case ($urandom_range(0, 3))
                0:       spread = 0;
                1:       spread = 40;
                2:       spread = 400;
                default: spread = 4095;
            endcase
            case ($urandom_range(0, 4))
                0:       sp = 0;
                1:       sp = 4095;
                default: begin
                    sp = center * 4 / 5 + 28 + int'($urandom_range(0, 200)) - 100;
                end
            endcase
            write_reg(REG_SET_POINT, {4'($urandom_range(0, 15)), 12'(sp)});
            write_reg(REG_BAND_ABOVE, pick_band());
            write_reg(REG_BAND_BELOW, pick_band());
            write_reg(REG_OK_ABOVE, pick_band());
            write_reg(REG_OK_BELOW, pick_band());
            case ($urandom_range(0, 4))
                0:       write_reg(REG_INITIAL_STEP, 16'h0000);
                1:       write_reg(REG_INITIAL_STEP, 16'hFFFF);
                2:       write_reg(REG_INITIAL_STEP, 16'h0001);
                default: write_reg(REG_INITIAL_STEP, 16'($urandom_range(0, 65535)));
            endcase
            if ($urandom_range(0, 1) == 1) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                          16'($urandom_range(0, 65535)));
            end
            blocks = $urandom_range(9, 13);
            repeat (blocks * BLK) begin
                if (spread == 4095) begin
                    smp = $urandom_range(0, 4095);
                end else begin
                    smp = center + int'($urandom_range(0, 2 * spread)) - spread;
                    if (smp < 0) smp = 0;
                    if (smp > 4095) smp = 4095;
                end
                send_sample(12'(smp));
            end
        end
    endtask

    // Receiver: ready drops in random bursts while stall_en is set.
    initial begin
        int hold;
        hold     = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                m_tready = 1'b0;
            end else if (stall_en && $urandom_range(0, 4) == 0) begin
                hold     = $urandom_range(0, 2);
                m_tready = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_block_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_blocks.size() == 0) begin
                report_mismatch("result with no block pending", int'(m_tdata[11:0]), 0);
            end else begin
                want = expected_blocks.pop_front();
                if (m_tdata[11:0] !== want.average_code)
                    report_mismatch("average_code", int'(m_tdata[11:0]),
                                    int'(want.average_code));
                if (m_tdata[27:12] !== want.duty)
                    report_mismatch("duty", int'(m_tdata[27:12]), int'(want.duty));
                if (m_tdata[28] !== want.in_band)
                    report_mismatch("in_band", int'(m_tdata[28]), int'(want.in_band));
            end
        end
    end

    // Watchdog: ends the run if no transfer happens on either stream for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[averaged_deadband_pwm_regulator] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_index    = REG_SET_POINT;
        i_cfg_data     = '0;
        cfg_shadow     = '0;
        step_shadow    = STEP_RST;
        duty_shadow    = '0;
        sample_tally   = 0;
        code_total     = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        stall_en       = 1'b1;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_band_wrap_and_step_load();
        test_zero_step_signed_window();
        test_random_phases();

        wait_for_results();
        if (mismatch_count == 0) begin
            $display("[averaged_deadband_pwm_regulator] OK");
        end else begin
            $display("[averaged_deadband_pwm_regulator] ERROR");
        end
        $finish;
    end

endmodule
